FILE: hdl/assert_macros.svh
// Assertion macros shared by the cache controller RTL.
// Depends on nothing; each macro samples on clk_i and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define MSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define MSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/msc_pkg.sv
// Shared types and constants for the MESI snooping cache controller.
// No dependencies; imported by every module of the block.
package msc_pkg;

  localparam int unsigned DefSets       = 256;
  localparam int unsigned DefWays       = 4;
  localparam int unsigned DefBlockBytes = 64;
  localparam int unsigned AddrW         = 32;

  typedef enum logic [2:0] {
    CMD_PR_RD   = 3'd0,
    CMD_PR_WR   = 3'd1,
    CMD_SN_RD   = 3'd2,
    CMD_SN_RDX  = 3'd3,
    CMD_SN_UPGR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPGR = 2'd3
  } bus_e;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_e;

  // Outcome of one request, as it leaves the update logic.
  typedef struct packed {
    logic [1:0] bus_action;
    logic       hit;
    logic       victim_writeback;
    logic       snoop_flush;
    logic       peer_transfer;
    logic [1:0] new_state;
  } result_t;

endpackage

FILE: hdl/msc_mem.sv
// Set memory: one row per set holding tags, MESI states and LRU ranks of all ways.
// Uses msc_pkg; a per-row valid bit makes unwritten rows read as invalid, rank zero.
module msc_mem #(
  parameter int unsigned SETS  = msc_pkg::DefSets,
  parameter int unsigned ROW_W = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     rd_en_i,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] rd_idx_i,
  output logic [ROW_W-1:0]                         rd_row_o,
  input  logic                                     wr_en_i,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] wr_idx_i,
  input  logic [ROW_W-1:0]                         wr_row_i
);
  import msc_pkg::*;

  logic [ROW_W-1:0] mem_q [SETS];
  logic [SETS-1:0]  row_valid_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_idx_i];
      end
    end
  end

  // An unwritten row reads as all ways invalid with rank zero.
  assign rd_row_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: hdl/msc_upd.sv
// Update logic: tag match, victim choice, MESI transitions and LRU rank update of one set.
// Uses msc_pkg; purely combinational, fed by the registered set row.
module msc_upd #(
  parameter int unsigned WAYS  = msc_pkg::DefWays,
  parameter int unsigned TAG_W = 18,
  parameter int unsigned ROW_W = 8
) (
  input  logic [2:0]        cmd_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic              shared_i,
  input  logic [ROW_W-1:0]  row_i,
  output logic [ROW_W-1:0]  row_o,
  output msc_pkg::result_t  res_o
);
  import msc_pkg::*;

  localparam int unsigned RankW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WayW  = TAG_W + 2 + RankW;
  localparam logic [RankW-1:0] TopRank = RankW'(WAYS - 1);

  logic [TAG_W-1:0] tag_r  [WAYS];
  logic [1:0]       st_r   [WAYS];
  logic [RankW-1:0] rank_r [WAYS];
  logic [TAG_W-1:0] tag_w  [WAYS];
  logic [1:0]       st_w   [WAYS];
  logic [RankW-1:0] rank_w [WAYS];

  logic [WAYS-1:0]  match;
  logic             hit;
  logic [RankW-1:0] hit_way;
  logic             any_inv;
  logic [RankW-1:0] inv_way;
  logic [RankW-1:0] lru_way;
  logic [RankW-1:0] vic_way;
  logic [RankW-1:0] touch_way;
  logic             do_touch;
  logic [RankW-1:0] old_rank;
  logic             is_proc;
  logic             is_snoop;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tag_r[j]  = row_i[j*WayW +: TAG_W];
      st_r[j]   = row_i[j*WayW + TAG_W +: 2];
      rank_r[j] = row_i[j*WayW + TAG_W + 2 +: RankW];
      match[j]  = (st_r[j] != ST_I) && (tag_r[j] == tag_i);
    end
  end

  // Lowest-numbered matching way, lowest invalid way, lowest-ranked way.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit     = 1'b1;
        hit_way = RankW'(j);
      end
      if (st_r[j] == ST_I) begin
        any_inv = 1'b1;
        inv_way = RankW'(j);
      end
    end
    for (int j = 1; j < WAYS; j++) begin
      if (rank_r[j] < rank_r[lru_way]) begin
        lru_way = RankW'(j);
      end
    end
    vic_way = any_inv ? inv_way : lru_way;
  end

  assign is_proc  = (cmd_i == CMD_PR_RD) || (cmd_i == CMD_PR_WR);
  assign is_snoop = (cmd_i == CMD_SN_RD) || (cmd_i == CMD_SN_RDX) || (cmd_i == CMD_SN_UPGR);

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tag_w[j]  = tag_r[j];
      st_w[j]   = st_r[j];
      rank_w[j] = rank_r[j];
    end
    res_o     = '0;
    do_touch  = 1'b0;
    touch_way = hit ? hit_way : vic_way;
    old_rank  = rank_r[touch_way];

    if (is_proc) begin
      do_touch = 1'b1;
      if (hit) begin
        res_o.hit = 1'b1;
        if (cmd_i == CMD_PR_WR) begin
          if (st_r[hit_way] == ST_S) begin
            res_o.bus_action = BUS_UPGR;
          end
          st_w[hit_way] = ST_M;
        end
        res_o.new_state = st_w[hit_way];
      end else begin
        res_o.victim_writeback = (st_r[vic_way] == ST_M);
        res_o.peer_transfer    = shared_i;
        tag_w[vic_way]         = tag_i;
        if (cmd_i == CMD_PR_WR) begin
          res_o.bus_action = BUS_RDX;
          st_w[vic_way]    = ST_M;
        end else begin
          res_o.bus_action = BUS_RD;
          st_w[vic_way]    = shared_i ? ST_S : ST_E;
        end
        res_o.new_state = st_w[vic_way];
      end
    end else if (is_snoop && hit) begin
      res_o.hit         = 1'b1;
      res_o.snoop_flush = (st_r[hit_way] == ST_M);
      if (cmd_i == CMD_SN_RD) begin
        if (st_r[hit_way] == ST_E || st_r[hit_way] == ST_M) begin
          st_w[hit_way] = ST_S;
        end
      end else begin
        st_w[hit_way] = ST_I;
      end
      res_o.new_state = st_w[hit_way];
    end

    if (do_touch) begin
      for (int j = 0; j < WAYS; j++) begin
        if (RankW'(j) == touch_way) begin
          rank_w[j] = TopRank;
        end else if (rank_r[j] > old_rank) begin
          rank_w[j] = rank_r[j] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      row_o[j*WayW +: WayW] = {rank_w[j], st_w[j], tag_w[j]};
    end
  end

endmodule

FILE: hdl/mesi_snooping_cache_controller_unit.sv
// Top level of the MESI snooping cache controller with true-LRU replacement.
// Uses msc_pkg, msc_mem, msc_upd and assert_macros.svh.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: address, shared
//  m_axis   | out       | tdata: bus_action, hit, victim_writeback, snoop_flush,
//           |           |        peer_transfer, new_state
//
// For each request the set row is read from the set memory when the request is
// accepted; in the lookup state the row is updated and written back while the result
// is loaded into the output register. The set memory has separate read and write ports.
// Reset is asynchronous and active low; it clears the per-set valid bits at once,
// so no clearing pass is needed and a request may be sent as soon as reset is released.
// A result that is not taken holds the block in its update cycle; a new request
// is accepted whenever the block is idle, even while a result still waits.
module mesi_snooping_cache_controller_unit #(
  parameter int unsigned SETS        = msc_pkg::DefSets,
  parameter int unsigned WAYS        = msc_pkg::DefWays,
  parameter int unsigned BLOCK_BYTES = msc_pkg::DefBlockBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [31:0] address, [32] shared, rest zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [1:0] bus_action, [2] hit, [3] victim_writeback,
                                     // [4] snoop_flush, [5] peer_transfer, [7:6] new_state
);
  import msc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned OffW  = $clog2(BLOCK_BYTES);
  localparam int unsigned IdxW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SetB  = $clog2(SETS);
  localparam int unsigned TagW  = AddrW - OffW - SetB;
  localparam int unsigned RankW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RowW  = WAYS * (TagW + 2 + RankW);

  // Controller states: idle waits for a request, look holds the row read.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic             state_q, state_d;
  logic [2:0]       cmd_q;
  logic [TagW-1:0]  tag_q;
  logic             shared_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  in_idx;
  logic             in_fire;
  logic             out_free;
  logic             commit;
  logic [RowW-1:0]  rd_row;
  logic [RowW-1:0]  wr_row;
  result_t          res;
  result_t          res_q;
  logic             out_valid_q;

  assign in_idx   = (SETS > 1) ? s_axis_tdata[OffW +: IdxW] : '0;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  // The row is written back in the same cycle the result enters the output register.
  assign commit   = (state_q == S_LOOK) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= s_axis_tuser;
      tag_q    <= s_axis_tdata[OffW + SetB +: TagW];
      shared_q <= s_axis_tdata[32];
      idx_q    <= in_idx;
    end
    if (commit) begin
      res_q <= res;
    end
  end

  msc_mem #(
    .SETS  (SETS),
    .ROW_W (RowW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_idx_i (in_idx),
    .rd_row_o (rd_row),
    .wr_en_i  (commit),
    .wr_idx_i (idx_q),
    .wr_row_i (wr_row)
  );

  msc_upd #(
    .WAYS  (WAYS),
    .TAG_W (TagW),
    .ROW_W (RowW)
  ) u_upd (
    .cmd_i    (cmd_q),
    .tag_i    (tag_q),
    .shared_i (shared_q),
    .row_i    (rd_row),
    .row_o    (wr_row),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.new_state, res_q.peer_transfer, res_q.snoop_flush,
                          res_q.victim_writeback, res_q.hit, res_q.bus_action};

  // A lookup cycle is always entered from an accepted request or stays put.
  `MSC_ASSERT_IMP(a_look_entry, $rose(state_q), $past(in_fire), "lookup without request")
  // A result carrying a flush must come from a hit.
  `MSC_ASSERT_IMP(a_flush_hit, out_valid_q && res_q.snoop_flush, res_q.hit, "flush on miss")
  // A writeback or peer transfer only happens on a miss.
  `MSC_ASSERT_IMP(a_miss_only, out_valid_q && (res_q.victim_writeback || res_q.peer_transfer),
                  !res_q.hit, "miss flag on hit")

endmodule
